[hdl/tcpl_pkg.sv]
// shared widths, codes and transaction types of the circumcenter and point locate unit
`default_nettype none
package tcpl_pkg;

  // coordinate format
  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;             // coordinate width
  localparam int DW        = CW + 1;         // vertex difference or sum
  localparam int PW        = 2 * DW;         // product of two differences
  localparam int EW        = 2 * CW + 1;     // E and F terms
  localparam int SW        = PW + 1;         // orientation determinant, signed
  localparam int MW        = SW - 1;         // determinant magnitude
  localparam int NW        = DW + EW;        // center numerator
  localparam int UW        = MW + 1;         // divisor |G|
  localparam int QW        = CW + 1;         // quotient bits kept by the divider
  localparam int SPLIT     = CW;             // low slice width for partial products

  // tolerance register
  localparam int              TW        = 16;
  localparam logic [TW-1:0]   TOL_RESET = 16'd66;

  typedef enum logic [1:0] {
    CST_VALID = 2'd0,
    CST_DEGEN = 2'd1,
    CST_SAT   = 2'd2
  } cst_t;

  typedef enum logic [1:0] {
    LOC_INSIDE   = 2'd0,
    LOC_BOUNDARY = 2'd1,
    LOC_OUTSIDE  = 2'd2,
    LOC_DEGEN    = 2'd3
  } loc_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx_in;
    logic signed [CW-1:0] cy_in;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [1:0]           center_status;
    logic [1:0]           location;
  } out_t;

  // geometry front end to numerator prep
  typedef struct packed {
    logic signed [DW-1:0] a_p;
    logic signed [DW-1:0] b_p;
    logic signed [DW-1:0] c_p;
    logic signed [DW-1:0] d_p;
    logic signed [EW-1:0] e;
    logic signed [EW-1:0] f;
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] l0;
    logic signed [SW-1:0] l1;
    logic signed [SW-1:0] l2;
  } geom_t;

  // prep to divider
  typedef struct packed {
    logic [NW-1:0] n_x;
    logic [NW-1:0] n_y;
    logic [UW-1:0] ud;
    logic          neg_x;
    logic          neg_y;
    logic          degen;
    loc_t          loc;
  } dvin_t;

  // divider to output stage
  typedef struct packed {
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic          ovf_x;
    logic          ovf_y;
    logic          neg_x;
    logic          neg_y;
    logic          degen;
    loc_t          loc;
  } dvout_t;

endpackage
`default_nettype wire

[hdl/tcpl_geom.sv]
// three-stage front end: differences, exact products, E/F/G and orientation sums
`default_nettype none
module tcpl_geom (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tcpl_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tcpl_pkg::geom_t      out_data
);
  import tcpl_pkg::*;

  function automatic logic signed [DW-1:0] dif(logic signed [CW-1:0] p,
                                               logic signed [CW-1:0] q);
    return DW'(p) - DW'(q);
  endfunction

  function automatic logic signed [DW-1:0] add(logic signed [CW-1:0] p,
                                               logic signed [CW-1:0] q);
    return DW'(p) + DW'(q);
  endfunction

  logic [2:0] vld_r;
  logic [3:0] rdy;

  // stage handshake, a stage loads when empty or when its successor moves
  assign rdy[3] = out_ready;
  for (genvar k = 0; k < 3; k++) begin : g_rdy
    assign rdy[k] = ~vld_r[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
    end
  end

  // stage 1: differences and sums
  logic signed [DW-1:0] ap_nxt, bp_nxt, cp_nxt, dp_nxt, sx1_nxt, sy1_nxt, sx2_nxt, sy2_nxt;
  logic signed [DW-1:0] ap_r, bp_r, cp_r, dp_r, sx1_r, sy1_r, sx2_r, sy2_r;
  logic signed [DW-1:0] ou_nxt [3], ov_nxt [3], ow_nxt [3], oz_nxt [3];
  logic signed [DW-1:0] ou_r [3], ov_r [3], ow_r [3], oz_r [3];

  always_comb begin
    ap_nxt  = dif(in_data.ax, in_data.cx_in);
    bp_nxt  = dif(in_data.ay, in_data.cy_in);
    cp_nxt  = dif(in_data.bx, in_data.cx_in);
    dp_nxt  = dif(in_data.by, in_data.cy_in);
    sx1_nxt = add(in_data.ax, in_data.cx_in);
    sy1_nxt = add(in_data.ay, in_data.cy_in);
    sx2_nxt = add(in_data.bx, in_data.cx_in);
    sy2_nxt = add(in_data.by, in_data.cy_in);
    // weight for vertex a: orient(p, b, c)
    ou_nxt[0] = dif(in_data.bx, in_data.point_x);
    ov_nxt[0] = dif(in_data.cy_in, in_data.point_y);
    ow_nxt[0] = dif(in_data.by, in_data.point_y);
    oz_nxt[0] = dif(in_data.cx_in, in_data.point_x);
    // weight for vertex b: orient(a, p, c)
    ou_nxt[1] = dif(in_data.point_x, in_data.ax);
    ov_nxt[1] = dif(in_data.cy_in, in_data.ay);
    ow_nxt[1] = dif(in_data.point_y, in_data.ay);
    oz_nxt[1] = dif(in_data.cx_in, in_data.ax);
    // weight for vertex c: orient(a, b, p)
    ou_nxt[2] = dif(in_data.bx, in_data.ax);
    ov_nxt[2] = dif(in_data.point_y, in_data.ay);
    ow_nxt[2] = dif(in_data.by, in_data.ay);
    oz_nxt[2] = dif(in_data.point_x, in_data.ax);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ap_r  <= ap_nxt;
      bp_r  <= bp_nxt;
      cp_r  <= cp_nxt;
      dp_r  <= dp_nxt;
      sx1_r <= sx1_nxt;
      sy1_r <= sy1_nxt;
      sx2_r <= sx2_nxt;
      sy2_r <= sy2_nxt;
      ou_r  <= ou_nxt;
      ov_r  <= ov_nxt;
      ow_r  <= ow_nxt;
      oz_r  <= oz_nxt;
    end
  end

  // stage 2: exact products
  logic signed [PW-1:0] pe1_nxt, pe2_nxt, pf1_nxt, pf2_nxt, pg1_nxt, pg2_nxt;
  logic signed [PW-1:0] pe1_r, pe2_r, pf1_r, pf2_r, pg1_r, pg2_r;
  logic signed [PW-1:0] op1_nxt [3], op2_nxt [3];
  logic signed [PW-1:0] op1_r [3], op2_r [3];
  logic signed [DW-1:0] ap2_r, bp2_r, cp2_r, dp2_r;

  always_comb begin
    pe1_nxt = ap_r * sx1_r;
    pe2_nxt = bp_r * sy1_r;
    pf1_nxt = cp_r * sx2_r;
    pf2_nxt = dp_r * sy2_r;
    pg1_nxt = ap_r * dp_r;
    pg2_nxt = bp_r * cp_r;
    for (int i = 0; i < 3; i++) begin
      op1_nxt[i] = ou_r[i] * ov_r[i];
      op2_nxt[i] = ow_r[i] * oz_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pe1_r <= pe1_nxt;
      pe2_r <= pe2_nxt;
      pf1_r <= pf1_nxt;
      pf2_r <= pf2_nxt;
      pg1_r <= pg1_nxt;
      pg2_r <= pg2_nxt;
      op1_r <= op1_nxt;
      op2_r <= op2_nxt;
      ap2_r <= ap_r;
      bp2_r <= bp_r;
      cp2_r <= cp_r;
      dp2_r <= dp_r;
    end
  end

  // stage 3: E, F, half of G and the three sub-triangle determinants
  geom_t g_nxt, g_r;

  always_comb begin
    g_nxt.a_p = ap2_r;
    g_nxt.b_p = bp2_r;
    g_nxt.c_p = cp2_r;
    g_nxt.d_p = dp2_r;
    g_nxt.e   = EW'(pe1_r + pe2_r);
    g_nxt.f   = EW'(pf1_r + pf2_r);
    g_nxt.s   = SW'(pg1_r) - SW'(pg2_r);
    g_nxt.l0  = SW'(op1_r[0]) - SW'(op2_r[0]);
    g_nxt.l1  = SW'(op1_r[1]) - SW'(op2_r[1]);
    g_nxt.l2  = SW'(op1_r[2]) - SW'(op2_r[2]);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) g_r <= g_nxt;
  end

  assign out_data = g_r;

endmodule
`default_nettype wire

[hdl/tcpl_prep.sv]
// five-stage numerator build, tolerance bound, point classification and divider operands
`default_nettype none
module tcpl_prep (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [tcpl_pkg::TW-1:0] edge_tol,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tcpl_pkg::geom_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tcpl_pkg::dvin_t       out_data
);
  import tcpl_pkg::*;

  localparam int HW   = PW + 1 + SPLIT;                // shifted high partial sum
  localparam int BNDW = TW + MW;                       // tolerance bound width
  localparam int LW   = ((SW + FRAC_BITS > BNDW) ? SW + FRAC_BITS : BNDW) + 2;
  localparam int NS   = 5;

  logic [NS-1:0] vld_r;
  logic [NS:0]   rdy;

  // stage handshake
  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld_r[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 4: partial products of the numerators, sign fold of the weights
  logic signed [DW-1:0] eh, el, fh, fl;
  logic signed [PW-1:0] deh_nxt, del_nxt, bfh_nxt, bfl_nxt, afh_nxt, afl_nxt, ceh_nxt, cel_nxt;
  logic signed [PW-1:0] deh_r, del_r, bfh_r, bfl_r, afh_r, afl_r, ceh_r, cel_r;
  logic [MW-1:0]        smag_nxt, smag4_r, smag5_r, smag6_r, smag7_r;
  logic                 sneg_nxt, sneg4_r, sneg5_r, sneg6_r;
  logic                 degen_nxt, degen4_r, degen5_r, degen6_r, degen7_r;
  logic signed [SW-1:0] la_nxt [3], la4_r [3], la5_r [3], la6_r [3];

  always_comb begin
    eh = $signed(in_data.e[EW-1:SPLIT]);
    el = $signed({1'b0, in_data.e[SPLIT-1:0]});
    fh = $signed(in_data.f[EW-1:SPLIT]);
    fl = $signed({1'b0, in_data.f[SPLIT-1:0]});
    deh_nxt = in_data.d_p * eh;
    del_nxt = in_data.d_p * el;
    bfh_nxt = in_data.b_p * fh;
    bfl_nxt = in_data.b_p * fl;
    afh_nxt = in_data.a_p * fh;
    afl_nxt = in_data.a_p * fl;
    ceh_nxt = in_data.c_p * eh;
    cel_nxt = in_data.c_p * el;
    sneg_nxt  = in_data.s[SW-1];
    degen_nxt = (in_data.s == '0);
    smag_nxt  = MW'(sneg_nxt ? -in_data.s : in_data.s);
    la_nxt[0] = sneg_nxt ? -in_data.l0 : in_data.l0;
    la_nxt[1] = sneg_nxt ? -in_data.l1 : in_data.l1;
    la_nxt[2] = sneg_nxt ? -in_data.l2 : in_data.l2;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      deh_r    <= deh_nxt;
      del_r    <= del_nxt;
      bfh_r    <= bfh_nxt;
      bfl_r    <= bfl_nxt;
      afh_r    <= afh_nxt;
      afl_r    <= afl_nxt;
      ceh_r    <= ceh_nxt;
      cel_r    <= cel_nxt;
      smag4_r  <= smag_nxt;
      sneg4_r  <= sneg_nxt;
      degen4_r <= degen_nxt;
      la4_r    <= la_nxt;
    end
  end

  // stage 5: high and low partial differences, tolerance partial products
  logic signed [PW:0]          hx_nxt, lx_nxt, hy_nxt, ly_nxt;
  logic signed [PW:0]          hx_r, lx_r, hy_r, ly_r;
  logic [TW+MW-SPLIT-1:0]      tph_nxt, tph_r;
  logic [TW+SPLIT-1:0]         tpl_nxt, tpl_r;
  logic [2:0]                  ins_nxt, ins5_r, ins6_r;

  always_comb begin
    hx_nxt  = (PW+1)'(deh_r) - (PW+1)'(bfh_r);
    lx_nxt  = (PW+1)'(del_r) - (PW+1)'(bfl_r);
    hy_nxt  = (PW+1)'(afh_r) - (PW+1)'(ceh_r);
    ly_nxt  = (PW+1)'(afl_r) - (PW+1)'(cel_r);
    tph_nxt = edge_tol * smag4_r[MW-1:SPLIT];
    tpl_nxt = edge_tol * smag4_r[SPLIT-1:0];
    for (int i = 0; i < 3; i++) begin
      ins_nxt[i] = (la4_r[i] > 0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      hx_r     <= hx_nxt;
      lx_r     <= lx_nxt;
      hy_r     <= hy_nxt;
      ly_r     <= ly_nxt;
      tph_r    <= tph_nxt;
      tpl_r    <= tpl_nxt;
      ins5_r   <= ins_nxt;
      la5_r    <= la4_r;
      smag5_r  <= smag4_r;
      sneg5_r  <= sneg4_r;
      degen5_r <= degen4_r;
    end
  end

  // stage 6: full numerators and the outside bound tol * |s|
  logic signed [NW-1:0] nx_nxt, ny_nxt, nx_r, ny_r;
  logic [BNDW-1:0]      bnd_nxt, bnd_r;

  always_comb begin
    nx_nxt  = NW'($signed({hx_r, SPLIT'(0)}) + HW'(lx_r));
    ny_nxt  = NW'($signed({hy_r, SPLIT'(0)}) + HW'(ly_r));
    bnd_nxt = BNDW'({tph_r, SPLIT'(0)}) + BNDW'(tpl_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      nx_r     <= nx_nxt;
      ny_r     <= ny_nxt;
      bnd_r    <= bnd_nxt;
      ins6_r   <= ins5_r;
      la6_r    <= la5_r;
      smag6_r  <= smag5_r;
      sneg6_r  <= sneg5_r;
      degen6_r <= degen5_r;
    end
  end

  // stage 7: numerator magnitudes and signs, outside test, location code
  logic [NW-1:0]        nabx_nxt, naby_nxt, nabx_r, naby_r;
  logic                 negx_nxt, negy_nxt, negx_r, negy_r;
  logic signed [LW-1:0] lsh, lsum;
  logic [2:0]           outs;
  loc_t                 loc_nxt, loc7_r;

  always_comb begin
    nabx_nxt = NW'(nx_r[NW-1] ? -nx_r : nx_r);
    naby_nxt = NW'(ny_r[NW-1] ? -ny_r : ny_r);
    negx_nxt = nx_r[NW-1] ^ sneg6_r;
    negy_nxt = ny_r[NW-1] ^ sneg6_r;
    lsh  = '0;
    lsum = '0;
    for (int i = 0; i < 3; i++) begin
      lsh     = LW'(la6_r[i]) <<< FRAC_BITS;
      lsum    = lsh + $signed(LW'(bnd_r));
      outs[i] = lsum[LW-1];
    end
    if (&ins6_r) begin
      loc_nxt = LOC_INSIDE;
    end else if (|outs) begin
      loc_nxt = LOC_OUTSIDE;
    end else begin
      loc_nxt = LOC_BOUNDARY;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      nabx_r   <= nabx_nxt;
      naby_r   <= naby_nxt;
      negx_r   <= negx_nxt;
      negy_r   <= negy_nxt;
      loc7_r   <= loc_nxt;
      smag7_r  <= smag6_r;
      degen7_r <= degen6_r;
    end
  end

  // stage 8: add half the divisor for round to nearest
  dvin_t dv_nxt, dv_r;

  always_comb begin
    dv_nxt.n_x   = nabx_r + NW'(smag7_r);
    dv_nxt.n_y   = naby_r + NW'(smag7_r);
    dv_nxt.ud    = {smag7_r, 1'b0};
    dv_nxt.neg_x = negx_r;
    dv_nxt.neg_y = negy_r;
    dv_nxt.degen = degen7_r;
    dv_nxt.loc   = loc7_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) dv_r <= dv_nxt;
  end

  assign out_data = dv_r;

endmodule
`default_nettype wire

[hdl/tcpl_div.sv]
// pipelined restoring divider, one quotient bit per stage for both center coordinates
`default_nettype none
module tcpl_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tcpl_pkg::dvin_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tcpl_pkg::dvout_t      out_data
);
  import tcpl_pkg::*;

  typedef struct packed {
    logic [NW-1:0] n_x;
    logic [NW-1:0] n_y;
    logic [UW-1:0] ud;
    logic [UW-1:0] r_x;
    logic [UW-1:0] r_y;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic          ovf_x;
    logic          ovf_y;
    logic          neg_x;
    logic          neg_y;
    logic          degen;
    loc_t          loc;
  } dst_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [UW:0] dstep(logic [UW-1:0] r, logic b, logic [UW-1:0] d);
    logic [UW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, UW'(t - {1'b0, d})};
    end
    return {1'b0, t[UW-1:0]};
  endfunction

  logic [QW:0]   vld_r;
  logic [QW+1:0] rdy;
  dst_t          st_r [QW+1];

  // stage handshake
  assign rdy[QW+1] = out_ready;
  for (genvar k = 0; k <= QW; k++) begin : g_rdy
    assign rdy[k] = ~vld_r[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k <= QW; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // entry stage: quotient too wide for the kept bits, initial remainder
  dst_t st0_nxt;

  always_comb begin
    st0_nxt.n_x   = in_data.n_x;
    st0_nxt.n_y   = in_data.n_y;
    st0_nxt.ud    = in_data.ud;
    st0_nxt.r_x   = UW'(in_data.n_x[NW-1:QW]);
    st0_nxt.r_y   = UW'(in_data.n_y[NW-1:QW]);
    st0_nxt.q_x   = '0;
    st0_nxt.q_y   = '0;
    st0_nxt.ovf_x = (UW'(in_data.n_x[NW-1:QW]) >= in_data.ud);
    st0_nxt.ovf_y = (UW'(in_data.n_y[NW-1:QW]) >= in_data.ud);
    st0_nxt.neg_x = in_data.neg_x;
    st0_nxt.neg_y = in_data.neg_y;
    st0_nxt.degen = in_data.degen;
    st0_nxt.loc   = in_data.loc;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) st_r[0] <= st0_nxt;
  end

  // bit stages, most significant quotient bit first
  for (genvar k = 1; k <= QW; k++) begin : g_step
    dst_t st_nxt;

    always_comb begin
      st_nxt = st_r[k-1];
      {st_nxt.q_x[QW-k], st_nxt.r_x} =
        dstep(st_r[k-1].r_x, st_r[k-1].n_x[QW-k], st_r[k-1].ud);
      {st_nxt.q_y[QW-k], st_nxt.r_y} =
        dstep(st_r[k-1].r_y, st_r[k-1].n_y[QW-k], st_r[k-1].ud);
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) st_r[k] <= st_nxt;
    end
  end

  always_comb begin
    out_data.q_x   = st_r[QW].q_x;
    out_data.q_y   = st_r[QW].q_y;
    out_data.ovf_x = st_r[QW].ovf_x;
    out_data.ovf_y = st_r[QW].ovf_y;
    out_data.neg_x = st_r[QW].neg_x;
    out_data.neg_y = st_r[QW].neg_y;
    out_data.degen = st_r[QW].degen;
    out_data.loc   = st_r[QW].loc;
  end

endmodule
`default_nettype wire

[hdl/triangle_circumcenter_point_locate_unit.sv]
// top level: tolerance register, front end, prep, divider and output register
//
// Takes one triangle (three vertices) and a query point per transaction on the
// in_ channel, all signed Q16.16, and returns one transaction on the out_
// channel with the rounded, saturated circumcenter, its status and the point's
// location code. Both channels are valid/ready; a transaction moves when valid
// and ready are high at a rising edge.
// From acceptance to out_valid a transaction passes 3 front end stages, 5 prep
// stages, 34 divider stages and the output register. The divider, one quotient
// bit per stage, makes up most of that path. One transaction is taken per cycle
// unless the output stalls; every stage holds its own valid bit, so bubbles close
// up and a new transaction is taken while a finished result waits at the output.
// When the receiver stalls, the pipeline fills and in_ready drops only once
// every stage is occupied; nothing is dropped or repeated.
// cfg_we writes edge_tolerance from cfg_wdata in the same cycle; write it only
// while the pipeline is empty. Synchronous reset (rst_n low) empties every
// stage and sets edge_tolerance to 66.
`default_nettype none
module triangle_circumcenter_point_locate_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire tcpl_pkg::in_t           in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output tcpl_pkg::out_t               out_data,
  input  wire logic                    cfg_we,
  input  wire logic [tcpl_pkg::TW-1:0] cfg_wdata
);
  import tcpl_pkg::*;

  localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (CW - 1));
  localparam logic [CW-1:0] SAT_POS = CW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [CW-1:0] SAT_NEG = CW'(64'd1 << (CW - 1));

  // round, sign and clamp one coordinate: returns {saturated, value}
  function automatic logic [CW:0] fix_coord(logic [QW-1:0] q, logic ovf, logic neg);
    logic sat;
    sat = ovf | (q > (neg ? LIM_NEG : LIM_POS));
    if (sat) begin
      return {1'b1, neg ? SAT_NEG : SAT_POS};
    end
    return {1'b0, neg ? CW'(-q) : CW'(q)};
  endfunction

  // tolerance register
  logic [TW-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // pipeline sections
  geom_t  geo_data;
  dvin_t  dvi_data;
  dvout_t dvo_data;
  logic   geo_valid, geo_ready, dvi_valid, dvi_ready, dvo_valid, dvo_ready;

  tcpl_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (geo_valid),
    .out_ready (geo_ready),
    .out_data  (geo_data)
  );

  tcpl_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .edge_tol  (tol_r),
    .in_valid  (geo_valid),
    .in_ready  (geo_ready),
    .in_data   (geo_data),
    .out_valid (dvi_valid),
    .out_ready (dvi_ready),
    .out_data  (dvi_data)
  );

  tcpl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dvi_valid),
    .in_ready  (dvi_ready),
    .in_data   (dvi_data),
    .out_valid (dvo_valid),
    .out_ready (dvo_ready),
    .out_data  (dvo_data)
  );

  // output register: saturation, status and degenerate override
  logic        out_valid_r;
  out_t        out_r, out_nxt;
  logic [CW:0] fx, fy;

  assign dvo_ready = ~out_valid_r | out_ready;

  always_comb begin
    fx = fix_coord(dvo_data.q_x, dvo_data.ovf_x, dvo_data.neg_x);
    fy = fix_coord(dvo_data.q_y, dvo_data.ovf_y, dvo_data.neg_y);
    if (dvo_data.degen) begin
      out_nxt.center_x      = '0;
      out_nxt.center_y      = '0;
      out_nxt.center_status = CST_DEGEN;
      out_nxt.location      = LOC_DEGEN;
    end else begin
      out_nxt.center_x      = $signed(fx[CW-1:0]);
      out_nxt.center_y      = $signed(fy[CW-1:0]);
      out_nxt.center_status = (fx[CW] | fy[CW]) ? CST_SAT : CST_VALID;
      out_nxt.location      = dvo_data.loc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dvo_ready) begin
      out_valid_r <= dvo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dvo_ready) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[hdl/tcpl_checker.sv]
// port-level checker for the circumcenter and point locate unit, with its bind
`default_nettype none
module tcpl_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire tcpl_pkg::out_t out_data
);
  import tcpl_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // degenerate location and degenerate status always come together
  a_degen_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.location == LOC_DEGEN) == (out_data.center_status == CST_DEGEN)))
    else $error("degenerate location and status disagree");

  // degenerate triangle reports a zero center
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.center_status == CST_DEGEN |->
      out_data.center_x == 0 && out_data.center_y == 0)
    else $error("degenerate triangle with nonzero center");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind triangle_circumcenter_point_locate_unit tcpl_checker u_tcpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
